// File: src/fmsd_pkg.sv
package fmsd_pkg;

    // Steps the controller asks of the datapath
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MULA,
        OP_MULB,
        OP_DIVI,
        OP_DIV,
        OP_SQI,
        OP_SQ,
        OP_OUTM,
        OP_OUTS,
        OP_OUTX,
        OP_CLR
    } op_t;

    typedef struct packed {
        op_t  op;
        logic set_sel;   // 0 levels, 1 deltas
        logic std_sel;   // 0 mean, 1 deviation
        logic last_res;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic n_zero;
        logic n_lt2;
    } sts_t;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WARMUP   = 2'd0;
    localparam logic [1:0] REG_LEVEL_EN = 2'd1;
    localparam logic [1:0] REG_DELTA_EN = 2'd2;

    localparam int SQ_STEPS = 32;
    localparam int ADDR_W   = 4;

endpackage

// File: src/fmsd_dp.sv
module fmsd_dp #(
    parameter int NUM_DIMS   = 8,
    parameter int MAX_FRAMES = 4096,
    parameter int DIMW       = 3,
    parameter int FW         = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic signed [23:0]    in_value,
    input  logic                  in_last,
    input  logic [7:0]            warmup,
    input  fmsd_pkg::cmd_t        cmd,
    input  logic [DIMW-1:0]       dim_sel,
    output fmsd_pkg::sts_t        sts,
    output logic [2:0]            m_dim,
    output logic [1:0]            m_kind,
    output logic signed [31:0]    m_stat,
    output logic                  m_valid_res,
    output logic                  m_done_res
);
    import fmsd_pkg::*;

    localparam int SW   = FW + 25;
    localparam int MAGW = FW + 24;
    localparam int QW   = FW + 48;
    localparam int NUMW = 2 * FW + 49;
    localparam int DENW = 2 * FW;
    localparam int CW   = (FW > 8 ? FW : 8) + 1;

    // Frame position and previous frame
    logic [DIMW-1:0]     di_reg;
    logic [FW-1:0]       fi_reg;
    logic signed [23:0]  prev_reg [NUM_DIMS];
    logic [FW-1:0]       nl_reg, nd_reg;

    logic                in_range, lvl_on, dl_on;
    logic [CW-1:0]       fi_c, wu_c, frames_c;
    logic signed [24:0]  dv;

    assign in_range = fi_reg < FW'(MAX_FRAMES);
    assign fi_c     = CW'(fi_reg);
    assign wu_c     = CW'(warmup);
    assign frames_c = in_range ? fi_c + CW'(1) : CW'(MAX_FRAMES);
    assign lvl_on   = in_range && (fi_c >= wu_c);
    assign dl_on    = in_range && (fi_c >= wu_c + CW'(1));
    assign dv       = 25'(in_value) - 25'(prev_reg[di_reg]);

    // Pipeline stage one
    logic                s1_valid_reg, s1_lvl_reg, s1_dl_reg;
    logic [DIMW-1:0]     s1_d_reg;
    logic signed [23:0]  s1_v_reg;
    logic signed [24:0]  s1_dv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.op == OP_CLR) begin
            di_reg       <= '0;
            fi_reg       <= '0;
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_DIMS; i++) prev_reg[i] <= '0;
        end else begin
            s1_valid_reg <= in_fire && in_range;
            if (in_fire) begin
                s1_lvl_reg <= lvl_on;
                s1_dl_reg  <= dl_on;
                s1_d_reg   <= di_reg;
                s1_v_reg   <= in_value;
                s1_dv_reg  <= dv;
                if (in_range) prev_reg[di_reg] <= in_value;
                if (in_last) begin
                    nl_reg <= (frames_c > wu_c) ? FW'(frames_c - wu_c) : '0;
                    nd_reg <= (frames_c > wu_c + CW'(1)) ?
                              FW'(frames_c - wu_c - CW'(1)) : '0;
                end else if (di_reg == DIMW'(NUM_DIMS - 1)) begin
                    di_reg <= '0;
                    if (in_range) fi_reg <= fi_reg + FW'(1);
                end else begin
                    di_reg <= di_reg + DIMW'(1);
                end
            end
        end
    end

    // Squares, registered before the accumulators
    logic [24:0] lm, dm;
    logic [49:0] lprod, dprod;
    assign lm    = s1_v_reg[23] ? 25'(-25'(s1_v_reg)) : 25'(s1_v_reg);
    assign dm    = s1_dv_reg[24] ? 25'(-s1_dv_reg) : 25'(s1_dv_reg);
    assign lprod = lm * lm;
    assign dprod = dm * dm;

    logic                s2_valid_reg, s2_lvl_reg, s2_dl_reg;
    logic [DIMW-1:0]     s2_d_reg;
    logic signed [23:0]  s2_v_reg;
    logic signed [24:0]  s2_dv_reg;
    logic [49:0]         s2_lp_reg, s2_dp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.op == OP_CLR) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        s2_lvl_reg <= s1_lvl_reg;
        s2_dl_reg  <= s1_dl_reg;
        s2_d_reg   <= s1_d_reg;
        s2_v_reg   <= s1_v_reg;
        s2_dv_reg  <= s1_dv_reg;
        s2_lp_reg  <= lprod;
        s2_dp_reg  <= dprod;
    end

    // Accumulators, one read address shared with the statistics sequence
    logic signed [SW-1:0] lsum_reg [NUM_DIMS];
    logic signed [SW-1:0] dsum_reg [NUM_DIMS];
    logic [QW-1:0]        lsq_reg  [NUM_DIMS];
    logic [QW-1:0]        dsq_reg  [NUM_DIMS];
    logic [DIMW-1:0]      rd_idx;
    logic signed [SW-1:0] lsum_rd, dsum_rd;
    logic [QW-1:0]        lsq_rd, dsq_rd;

    assign rd_idx  = (cmd.op == OP_LOAD) ? dim_sel : s2_d_reg;
    assign lsum_rd = lsum_reg[rd_idx];
    assign dsum_rd = dsum_reg[rd_idx];
    assign lsq_rd  = lsq_reg[rd_idx];
    assign dsq_rd  = dsq_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.op == OP_CLR) begin
            for (int i = 0; i < NUM_DIMS; i++) begin
                lsum_reg[i] <= '0;
                dsum_reg[i] <= '0;
                lsq_reg[i]  <= '0;
                dsq_reg[i]  <= '0;
            end
        end else if (s2_valid_reg) begin
            if (s2_lvl_reg) begin
                lsum_reg[s2_d_reg] <= lsum_rd + SW'(s2_v_reg);
                lsq_reg[s2_d_reg]  <= lsq_rd + QW'(s2_lp_reg);
            end
            if (s2_dl_reg) begin
                dsum_reg[s2_d_reg] <= dsum_rd + SW'(s2_dv_reg);
                dsq_reg[s2_d_reg]  <= dsq_rd + QW'(s2_dp_reg);
            end
        end
    end

    // Status towards the controller
    logic [FW-1:0] n_sel;
    assign n_sel = cmd.set_sel ? nd_reg : nl_reg;

    always_comb begin
        sts.pipe_busy = s1_valid_reg | s2_valid_reg;
        sts.n_zero    = (n_sel == '0);
        sts.n_lt2     = (n_sel < FW'(2));
    end

    // Statistics engine: serial multiply, restoring divide, square root
    logic                 neg_reg;
    logic [MAGW-1:0]      mag_reg, msh_reg;
    logic [QW-1:0]        sq_reg;
    logic [FW-1:0]        nsh_reg;
    logic [DENW-1:0]      den_reg, rem_reg;
    logic [NUMW-1:0]      acc_reg, prd_reg, qsh_reg;
    logic [63:0]          sx_reg, sres_reg, sbit_reg;

    logic signed [SW-1:0] sum_sel;
    logic [DENW:0]        rt;
    logic [63:0]          st;
    logic [31:0]          stat_m, stat_s;

    assign sum_sel = cmd.set_sel ? dsum_rd : lsum_rd;
    assign rt      = {rem_reg, qsh_reg[NUMW-1]};
    assign st      = sres_reg + sbit_reg;

    always_comb begin
        if (neg_reg) begin
            stat_m = (qsh_reg > NUMW'(64'h8000_0000)) ? 32'h8000_0000 :
                     32'(NUMW'(0) - qsh_reg);
        end else begin
            stat_m = (qsh_reg > NUMW'(64'h7fff_ffff)) ? 32'h7fff_ffff : qsh_reg[31:0];
        end
        stat_s = (sres_reg > 64'h7fff_ffff) ? 32'h7fff_ffff : sres_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                neg_reg <= sum_sel[SW-1];
                mag_reg <= MAGW'(sum_sel[SW-1] ? -sum_sel : sum_sel);
                msh_reg <= MAGW'(sum_sel[SW-1] ? -sum_sel : sum_sel);
                sq_reg  <= cmd.set_sel ? dsq_rd : lsq_rd;
                nsh_reg <= n_sel;
                den_reg <= DENW'(n_sel) * DENW'(n_sel - FW'(1));
                acc_reg <= '0;
                prd_reg <= '0;
            end
            OP_MULA: begin
                acc_reg <= (acc_reg << 1) + (nsh_reg[FW-1] ? NUMW'(sq_reg) : '0);
                nsh_reg <= nsh_reg << 1;
            end
            OP_MULB: begin
                prd_reg <= (prd_reg << 1) + (msh_reg[MAGW-1] ? NUMW'(mag_reg) : '0);
                msh_reg <= msh_reg << 1;
            end
            OP_DIVI: begin
                qsh_reg <= cmd.std_sel ? acc_reg - prd_reg : NUMW'(mag_reg);
                rem_reg <= '0;
                if (!cmd.std_sel) den_reg <= DENW'(n_sel);
            end
            OP_DIV: begin
                if (rt >= {1'b0, den_reg}) begin
                    rem_reg <= DENW'(rt - {1'b0, den_reg});
                    qsh_reg <= {qsh_reg[NUMW-2:0], 1'b1};
                end else begin
                    rem_reg <= rt[DENW-1:0];
                    qsh_reg <= {qsh_reg[NUMW-2:0], 1'b0};
                end
            end
            OP_SQI: begin
                sx_reg   <= 64'(qsh_reg);
                sres_reg <= '0;
                sbit_reg <= 64'h4000_0000_0000_0000;
            end
            OP_SQ: begin
                if (sx_reg >= st) begin
                    sx_reg   <= sx_reg - st;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end else begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            default: ;
        endcase
    end

    // Output word
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUTM || cmd.op == OP_OUTS || cmd.op == OP_OUTX) begin
            m_dim      <= 3'(dim_sel);
            m_kind     <= {cmd.set_sel, cmd.std_sel};
            m_done_res <= cmd.last_res;
            case (cmd.op)
                OP_OUTM: begin
                    m_stat      <= stat_m;
                    m_valid_res <= 1'b1;
                end
                OP_OUTS: begin
                    m_stat      <= stat_s;
                    m_valid_res <= 1'b1;
                end
                default: begin
                    m_stat      <= '0;
                    m_valid_res <= 1'b0;
                end
            endcase
        end
    end

endmodule

// File: src/fmsd_ctrl.sv
module fmsd_ctrl #(
    parameter int NUM_DIMS   = 8,
    parameter int DIMW       = 3,
    parameter int FW         = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic             in_last,
    input  logic             m_ready,
    input  logic             level_en,
    input  logic             delta_en,
    input  fmsd_pkg::sts_t   sts,
    output logic             s_ready,
    output logic             m_valid,
    output fmsd_pkg::cmd_t   cmd,
    output logic [DIMW-1:0]  dim_sel
);
    import fmsd_pkg::*;

    localparam int MAGW = FW + 24;
    localparam int NUMW = 2 * FW + 49;
    localparam int CNTW = $clog2(NUMW + 1);

    typedef enum logic [11:0] {
        ST_ACC   = 12'b0000_0000_0001,
        ST_DRAIN = 12'b0000_0000_0010,
        ST_LOAD  = 12'b0000_0000_0100,
        ST_MULA  = 12'b0000_0000_1000,
        ST_MULB  = 12'b0000_0001_0000,
        ST_DIVI  = 12'b0000_0010_0000,
        ST_DIV   = 12'b0000_0100_0000,
        ST_SQI   = 12'b0000_1000_0000,
        ST_SQ    = 12'b0001_0000_0000,
        ST_FIN   = 12'b0010_0000_0000,
        ST_OUT   = 12'b0100_0000_0000,
        ST_CLR   = 12'b1000_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DIMW-1:0] dim_reg, dim_next;
    logic            set_reg, set_next;
    logic            std_reg, std_next;
    logic            bad_reg, bad_next;
    logic            last_res;

    assign last_res = std_reg && (dim_reg == DIMW'(NUM_DIMS - 1)) && (set_reg || !delta_en);

    assign s_ready      = (state_reg == ST_ACC);
    assign m_valid      = (state_reg == ST_OUT);
    assign dim_sel      = dim_reg;

    // Sequence the statistics, one word at a time
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        dim_next     = dim_reg;
        set_next     = set_reg;
        std_next     = std_reg;
        bad_next     = bad_reg;
        cmd.set_sel  = set_reg;
        cmd.std_sel  = std_reg;
        cmd.last_res = last_res;
        cmd.op       = OP_NONE;
        unique case (state_reg)
            ST_ACC: begin
                if (in_fire && in_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                dim_next = '0;
                std_next = 1'b0;
                if (!sts.pipe_busy) begin
                    if (level_en) begin
                        set_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else if (delta_en) begin
                        set_next   = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_CLR;
                    end
                end
            end
            ST_LOAD: begin
                cmd.op   = OP_LOAD;
                bad_next = std_reg ? sts.n_lt2 : sts.n_zero;
                if (std_reg ? sts.n_lt2 : sts.n_zero) begin
                    state_next = ST_FIN;
                end else if (std_reg) begin
                    cnt_next   = CNTW'(FW);
                    state_next = ST_MULA;
                end else begin
                    state_next = ST_DIVI;
                end
            end
            ST_MULA: begin
                cmd.op   = OP_MULA;
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    cnt_next   = CNTW'(MAGW);
                    state_next = ST_MULB;
                end
            end
            ST_MULB: begin
                cmd.op   = OP_MULB;
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) state_next = ST_DIVI;
            end
            ST_DIVI: begin
                cmd.op     = OP_DIVI;
                cnt_next   = CNTW'(NUMW);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) state_next = std_reg ? ST_SQI : ST_FIN;
            end
            ST_SQI: begin
                cmd.op     = OP_SQI;
                cnt_next   = CNTW'(SQ_STEPS);
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.op   = OP_SQ;
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.op     = bad_reg ? OP_OUTX : (std_reg ? OP_OUTS : OP_OUTM);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (last_res) begin
                        state_next = ST_CLR;
                    end else begin
                        state_next = ST_LOAD;
                        if (dim_reg == DIMW'(NUM_DIMS - 1)) begin
                            dim_next = '0;
                            if (!std_reg) begin
                                std_next = 1'b1;
                            end else begin
                                std_next = 1'b0;
                                set_next = 1'b1;
                            end
                        end else begin
                            dim_next = dim_reg + DIMW'(1);
                        end
                    end
                end
            end
            ST_CLR: begin
                cmd.op     = OP_CLR;
                state_next = ST_ACC;
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
            dim_reg   <= '0;
            set_reg   <= 1'b0;
            std_reg   <= 1'b0;
            bad_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dim_reg   <= dim_next;
            set_reg   <= set_next;
            std_reg   <= std_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

// File: src/feature_mean_std_with_deltas.sv
// Per-dimension mean and sample standard deviation of feature levels and
// of their frame-to-frame differences.
// Input channel (s_valid/s_ready): one signed Q8.16 element per word, frame
// by frame, dimension 0 first; s_last marks the final element of a run.
// Elements are taken one per cycle while the block accumulates.
// After s_last, s_ready stays low while the accumulator pipeline empties,
// and then while the results are worked out one at a time by a shared
// serial multiply, restoring divider and square-root unit.
// Result channel (m_valid/m_ready): per enabled set, all means, then all
// deviations. Most of the time for each result is spent in the divider's
// one-bit-per-cycle loop, whose length grows with FW = clog2(MAX_FRAMES+1).
// A result waits in its output register while m_ready is low; nothing
// else advances. After the last result is taken, the ST_CLR state clears
// the accumulators and s_ready rises again.
// Reset clears all statistics and loads warmup 0, both sets enabled.
// Registers (APB): 0x0 warmup_frames, 0x4 level_enable, 0x8 delta_enable.
module feature_mean_std_with_deltas #(
    parameter int NUM_DIMS   = 8,
    parameter int MAX_FRAMES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [23:0]            s_value,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_dim,
    output logic [1:0]                    m_kind,
    output logic signed [31:0]            m_stat,
    output logic                          m_valid_res,
    output logic                          m_done_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmsd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import fmsd_pkg::*;

    localparam int FW   = $clog2(MAX_FRAMES + 1);
    localparam int DIMW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

    // Configuration registers
    logic [7:0] warmup_reg;
    logic       level_en_reg, delta_en_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warmup_reg   <= '0;
            level_en_reg <= 1'b1;
            delta_en_reg <= 1'b1;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_WARMUP:   warmup_reg   <= pwdata[7:0];
                REG_LEVEL_EN: level_en_reg <= pwdata[0];
                REG_DELTA_EN: delta_en_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WARMUP:   prdata = 32'(warmup_reg);
            REG_LEVEL_EN: prdata = 32'(level_en_reg);
            REG_DELTA_EN: prdata = 32'(delta_en_reg);
            default:      prdata = '0;
        endcase
    end

    logic            in_fire;
    cmd_t            cmd;
    sts_t            sts;
    logic [DIMW-1:0] dim_sel;

    assign in_fire = s_valid && s_ready;

    fmsd_ctrl #(
        .NUM_DIMS (NUM_DIMS),
        .DIMW     (DIMW),
        .FW       (FW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_last  (s_last),
        .m_ready  (m_ready),
        .level_en (level_en_reg),
        .delta_en (delta_en_reg),
        .sts      (sts),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .cmd      (cmd),
        .dim_sel  (dim_sel)
    );

    fmsd_dp #(
        .NUM_DIMS   (NUM_DIMS),
        .MAX_FRAMES (MAX_FRAMES),
        .DIMW       (DIMW),
        .FW         (FW)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_value    (s_value),
        .in_last     (s_last),
        .warmup      (warmup_reg),
        .cmd         (cmd),
        .dim_sel     (dim_sel),
        .sts         (sts),
        .m_dim       (m_dim),
        .m_kind      (m_kind),
        .m_stat      (m_stat),
        .m_valid_res (m_valid_res),
        .m_done_res  (m_done_res)
    );

endmodule

// File: dv/feature_mean_std_with_deltas_test.sv
`timescale 1ns / 1ps

module feature_mean_std_with_deltas_test;
    import fmsd_pkg::*;

    localparam int NDIM       = 8;
    localparam int FRAME_CAP  = 4096;
    localparam int LIMIT      = 4000000;
    localparam int CLEAR_WAIT = 40;

    localparam logic [1:0] KIND_MEAN   = 2'd0;
    localparam logic [1:0] KIND_STD    = 2'd1;
    localparam logic [1:0] KIND_DMEAN  = 2'd2;
    localparam logic [1:0] KIND_DSTD   = 2'd3;

    typedef struct {
        logic signed [23:0] value;
        logic               last;
    } element_t;

    typedef struct {
        logic [2:0]         dim;
        logic [1:0]         kind;
        logic signed [31:0] stat;
        logic               valid_res;
        logic               done_res;
    } stat_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [23:0] s_value = '0;
    logic s_last = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [2:0] m_dim;
    logic [1:0] m_kind;
    logic signed [31:0] m_stat;
    logic m_valid_res;
    logic m_done_res;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    feature_mean_std_with_deltas DUT (.*);

    always #1 aclk = ~aclk;

    // shadow registers and accumulators
    int warmup_sh = 0;
    bit level_en_sh = 1;
    bit delta_en_sh = 1;
    logic signed [63:0] lvl_sum [NDIM];
    logic [127:0]       lvl_sq  [NDIM];
    logic signed [63:0] dlt_sum [NDIM];
    logic [127:0]       dlt_sq  [NDIM];
    logic signed [63:0] prev_val [NDIM];
    int frame_cnt = 0;
    int dim_cnt = 0;

    element_t pending_words [$];
    stat_t    expected_stats [$];
    int  failures = 0;
    int  items_sent = 0;
    bit  no_idle = 0;
    bit  hold_tog = 0;
    longint cycles = 0;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r, b, t;
        begin
            r = 0;
            t = x;
            b = 64'h4000_0000_0000_0000;
            while (b > t) b = b >> 2;
            while (b != 0) begin
                if (t >= r + b) begin
                    t = t - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic void clear_stats();
        for (int d = 0; d < NDIM; d++) begin
            lvl_sum[d] = 0; lvl_sq[d] = 0; dlt_sum[d] = 0; dlt_sq[d] = 0; prev_val[d] = 0;
        end
        frame_cnt = 0;
        dim_cnt = 0;
    endfunction

    // queue means then deviations of one set
    function automatic void queue_set(input bit deltas, input longint n);
        stat_t e;
        logic signed [63:0] s;
        logic [127:0] sq, mag, num, q;
        logic [63:0] var64, root;
        for (int d = 0; d < NDIM; d++) begin
            e.dim = d[2:0];
            e.kind = deltas ? KIND_DMEAN : KIND_MEAN;
            e.done_res = 0;
            s = deltas ? dlt_sum[d] : lvl_sum[d];
            e.valid_res = (n != 0);
            e.stat = (n == 0) ? 32'sd0 : sat32(s / n);
            expected_stats.push_back(e);
        end
        for (int d = 0; d < NDIM; d++) begin
            e.dim = d[2:0];
            e.kind = deltas ? KIND_DSTD : KIND_STD;
            e.done_res = 0;
            e.valid_res = (n >= 2);
            e.stat = 0;
            if (n >= 2) begin
                s = deltas ? dlt_sum[d] : lvl_sum[d];
                sq = deltas ? dlt_sq[d] : dlt_sq[d] ^ dlt_sq[d] ^ lvl_sq[d];
                mag = {64'd0, (s < 0) ? -s : s};
                num = sq * n - mag * mag;
                q = num / (n * (n - 1));
                var64 = (q[127:64] != 0) ? '1 : q[63:0];
                root = isqrt64(var64);
                e.stat = (root > 64'd2147483647) ? 32'sh7fffffff : root[31:0];
            end
            expected_stats.push_back(e);
        end
    endfunction

    // accumulate one accepted word and queue what it causes
    function automatic void predict_word(input element_t w);
        logic signed [63:0] v, dv;
        logic [127:0] m;
        longint frames, nl, nd;
        int first_new;
        v = w.value;
        if (frame_cnt < FRAME_CAP && dim_cnt < NDIM) begin
            if (frame_cnt >= warmup_sh) begin
                m = {64'd0, (v < 0) ? -v : v};
                lvl_sum[dim_cnt] += v;
                lvl_sq[dim_cnt] += m * m;
            end
            if (frame_cnt >= warmup_sh + 1) begin
                dv = v - prev_val[dim_cnt];
                m = {64'd0, (dv < 0) ? -dv : dv};
                dlt_sum[dim_cnt] += dv;
                dlt_sq[dim_cnt] += m * m;
            end
            prev_val[dim_cnt] = v;
        end
        if (!w.last) begin
            dim_cnt++;
            if (dim_cnt >= NDIM) begin
                dim_cnt = 0;
                if (frame_cnt < FRAME_CAP) frame_cnt++;
            end
            return;
        end
        frames = frame_cnt + 1;
        if (frames > FRAME_CAP) frames = FRAME_CAP;
        nl = (frames > warmup_sh) ? frames - warmup_sh : 0;
        nd = (frames > warmup_sh + 1) ? frames - warmup_sh - 1 : 0;
        first_new = expected_stats.size();
        if (level_en_sh) queue_set(0, nl);
        if (delta_en_sh) queue_set(1, nd);
        if (expected_stats.size() > first_new) expected_stats[$].done_res = 1;
        clear_stats();
    endfunction

    // driver: offer pending words with random gaps
    int s_gap = 0;
    always @(posedge aclk) begin
        element_t w;
        if (!aresetn) begin
            s_valid <= 0;
            s_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                w.value = s_value;
                w.last = s_last;
                predict_word(w);
                s_gap = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 0;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    s_valid <= 1;
                    s_value <= w.value;
                    s_last <= w.last;
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // monitor: check results, stall at random
    int m_gap = 0;
    int hold_cnt = 0;
    bit hold_seen = 0;
    always @(posedge aclk) begin
        stat_t e;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected word dim %0d kind %0d stat %0d",
                             $time, m_dim, m_kind, m_stat);
                    failures++;
                end else begin
                    e = expected_stats.pop_front();
                    if (m_dim !== e.dim || m_kind !== e.kind || m_stat !== e.stat ||
                        m_valid_res !== e.valid_res || m_done_res !== e.done_res) begin
                        $display("%0t: expected dim %0d kind %0d stat %0d valid %0b done %0b",
                                 $time, e.dim, e.kind, e.stat, e.valid_res, e.done_res);
                        $display("%0t: actual   dim %0d kind %0d stat %0d valid %0b done %0b",
                                 $time, m_dim, m_kind, m_stat, m_valid_res, m_done_res);
                        failures++;
                    end
                end
                m_gap = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (hold_tog != hold_seen) begin
                hold_seen = hold_tog;
                hold_cnt = 600;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_WARMUP:   warmup_sh = data[7:0];
            REG_LEVEL_EN: level_en_sh = data[0];
            REG_DELTA_EN: delta_en_sh = data[0];
            default: ;
        endcase
    endtask

    // wait until all words are taken and all results are in
    task automatic drain();
        do @(posedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_stats.size() != 0);
        repeat (CLEAR_WAIT) @(posedge aclk);
    endtask

    function automatic logic signed [23:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return 24'sh000000;
            default: return 24'($urandom());
        endcase
    endfunction

    // queue one run of frames; the final frame may stop early
    task automatic queue_run(input int nframes, input int last_dim);
        element_t w;
        for (int f = 0; f < nframes; f++)
            for (int d = 0; d < NDIM; d++) begin
                if (f == nframes - 1 && d > last_dim) break;
                w.value = pick_value();
                w.last = (f == nframes - 1 && d == last_dim);
                pending_words.push_back(w);
                items_sent++;
            end
    endtask

    task automatic queue_word(input logic signed [23:0] v, input logic l);
        element_t w;
        w.value = v;
        w.last = l;
        pending_words.push_back(w);
        items_sent++;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        clear_stats();

        // one frame of extremes: means only
        queue_word(24'sh7fffff, 1'b0); queue_word(24'sh800000, 1'b0);
        queue_word(24'sh000000, 1'b0); queue_word(24'sh000001, 1'b0);
        queue_word(-24'sd1, 1'b0);     queue_word(24'sh555555, 1'b0);
        queue_word(24'shaaaaaa, 1'b0); queue_word(24'sh7fffff, 1'b1);
        drain();
        // two full frames and a short third frame, swinging full range;
        // hold the receiver off while a further run presses on the input
        hold_tog = ~hold_tog;
        for (int i = 0; i < 8; i++) queue_word(i[0] ? 24'sh800000 : 24'sh7fffff, 1'b0);
        for (int i = 0; i < 8; i++) queue_word(i[0] ? 24'sh7fffff : 24'sh800000, 1'b0);
        queue_word(24'sh012345, 1'b0); queue_word(-24'sd77, 1'b1);
        queue_run(2, 7);
        drain();
        // warmup past the run: nothing valid
        reg_write(REG_WARMUP, 3);
        queue_run(2, 7);
        drain();
        // both sets off: no results
        reg_write(REG_LEVEL_EN, 0);
        reg_write(REG_DELTA_EN, 0);
        queue_run(1, 2);
        drain();

        // random runs under changing settings
        while (items_sent < 190) begin
            reg_write(REG_WARMUP, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 2));
            reg_write(REG_LEVEL_EN, 32'($urandom_range(0, 4) != 0));
            reg_write(REG_DELTA_EN, 32'($urandom_range(0, 4) != 0));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3))
                queue_run((warmup_sh > 3 ? 0 : warmup_sh) + $urandom_range(1, 4),
                          ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 7);
            drain();
        end

        repeat (100) @(posedge aclk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: feature_mean_std_with_deltas.f
src/fmsd_pkg.sv
src/fmsd_dp.sv
src/fmsd_ctrl.sv
src/feature_mean_std_with_deltas.sv
dv/feature_mean_std_with_deltas_test.sv
